@@ rtl/cbb_pkg.sv @@
`default_nettype none
package cbb_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int FIELD_W = 13;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [FIELD_W-1:0] CAP_RESET = 13'd4096;

    // Operation codes carried by func.
    localparam logic [3:0] F_SET_POS = 4'd8;
    localparam logic [3:0] F_SET_LIMIT = 4'd9;
    localparam logic [3:0] F_MARK = 4'd10;
    localparam logic [3:0] F_RESET = 4'd11;
    localparam logic [3:0] F_CLEAR = 4'd12;
    localparam logic [3:0] F_FLIP = 4'd13;
    localparam logic [3:0] F_REWIND = 4'd14;
    localparam logic [3:0] F_COMPACT = 4'd15;

    // Configuration register indexes.
    localparam logic [1:0] REG_ELEM_SIZE = 2'd0;
    localparam logic [1:0] REG_CAPACITY = 2'd1;
    localparam logic [1:0] REG_BYTE_ORDER = 2'd2;
    localparam logic [1:0] REG_READ_ONLY = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_INDEX = 3'd3;
    localparam logic [2:0] ST_READ_ONLY = 3'd4;
    localparam logic [2:0] ST_ARGUMENT = 3'd5;
    localparam logic [2:0] ST_MARK = 3'd6;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_READ = 2'd1,
        OP_WRITE = 2'd2,
        OP_COMPACT = 2'd3
    } op_t;

    typedef struct packed {
        op_t op;
        logic [ADDR_W-1:0] addr;
        logic [1:0] size_code;
        logic [ADDR_W:0] len;
        logic msb_first;
        logic [63:0] wdata;
        logic [2:0] status;
        logic [FIELD_W-1:0] pos;
        logic [FIELD_W-1:0] lim;
    } cmd_t;

    function automatic logic [FIELD_W-1:0] eff_cap(input logic [1:0] esc,
                                                   input logic [FIELD_W-1:0] cap);
        logic [ADDR_W+4:0] most;
        most = (ADDR_W+5)'(STORE_BYTES) >> esc;
        if ((ADDR_W+5)'(cap) < most)
            return cap;
        else
            return most[FIELD_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/cbb_front.sv @@
`default_nettype none
module cbb_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [12:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [3:0]           func,
    input  wire logic [12:0]          index,
    input  wire logic [1:0]           scalar_size_code,
    input  wire logic [63:0]          write_value,
    input  wire logic                 q_full,
    input  wire logic                 clearing,
    output logic                      q_push,
    output cbb_pkg::cmd_t             q_cmd,
    output logic                      rebuild
);

    logic [1:0]  esc_reg, esc_next;
    logic [12:0] cap_reg, cap_next;
    logic        be_reg, be_next;
    logic        ro_reg, ro_next;
    logic [12:0] pos_reg, pos_next;
    logic [12:0] lim_reg, lim_next;
    logic [12:0] mark_reg, mark_next;
    logic        mv_reg, mv_next;

    logic        scalar, rel, put;
    logic [1:0]  szc;
    logic [13:0] units, end_at;
    logic [12:0] at, cap_now, count;
    logic [15:0] byte_at, src, len;

    assign in_stall = q_full | clearing | cfg_we;

    always_comb
    begin
        esc_next = esc_reg;
        cap_next = cap_reg;
        be_next = be_reg;
        ro_next = ro_reg;
        pos_next = pos_reg;
        lim_next = lim_reg;
        mark_next = mark_reg;
        mv_next = mv_reg;
        rebuild = 1'b0;
        q_push = 1'b0;
        q_cmd = '0;
        q_cmd.op = cbb_pkg::OP_NONE;
        q_cmd.status = cbb_pkg::ST_OK;

        scalar = func[2];
        rel = ~func[0];
        put = func[1];
        szc = scalar ? scalar_size_code : esc_reg;
        units = scalar ? (14'd1 << scalar_size_code) : 14'd1;
        at = rel ? pos_reg : index;
        end_at = {1'b0, at} + units;
        byte_at = scalar ? {3'b000, at} : ({3'b000, at} << szc);
        cap_now = cbb_pkg::eff_cap(esc_reg, cap_reg);
        count = (lim_reg > pos_reg) ? (lim_reg - pos_reg) : 13'd0;
        src = {3'b000, pos_reg} << esc_reg;
        len = {3'b000, count} << esc_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                cbb_pkg::REG_ELEM_SIZE:
                begin
                    esc_next = cfg_data[1:0];
                    rebuild = 1'b1;
                end
                cbb_pkg::REG_CAPACITY:
                begin
                    cap_next = cfg_data;
                    rebuild = 1'b1;
                end
                cbb_pkg::REG_BYTE_ORDER: be_next = cfg_data[0];
                cbb_pkg::REG_READ_ONLY:  ro_next = cfg_data[0];
                default: ;
            endcase
            if (rebuild)
            begin
                pos_next = '0;
                lim_next = cbb_pkg::eff_cap(esc_next, cap_next);
                mark_next = '0;
                mv_next = 1'b0;
            end
        end
        else if (in_valid && !in_stall)
        begin
            q_push = 1'b1;
            if (!func[3])
            begin
                if (put && ro_reg)
                    q_cmd.status = cbb_pkg::ST_READ_ONLY;
                else if (end_at > {1'b0, lim_reg})
                    q_cmd.status = rel ? (put ? cbb_pkg::ST_OVERFLOW : cbb_pkg::ST_UNDERFLOW)
                                       : cbb_pkg::ST_INDEX;
                else
                begin
                    q_cmd.op = put ? cbb_pkg::OP_WRITE : cbb_pkg::OP_READ;
                    q_cmd.addr = byte_at[cbb_pkg::ADDR_W-1:0];
                    if (rel)
                        pos_next = end_at[12:0];
                end
            end
            else
            begin
                case (func)
                    cbb_pkg::F_SET_POS:
                        if (index > lim_reg)
                            q_cmd.status = cbb_pkg::ST_ARGUMENT;
                        else
                        begin
                            pos_next = index;
                            if (mark_reg > index)
                                mv_next = 1'b0;
                        end
                    cbb_pkg::F_SET_LIMIT:
                        if (index > cap_now)
                            q_cmd.status = cbb_pkg::ST_ARGUMENT;
                        else
                        begin
                            lim_next = index;
                            if (pos_reg > index)
                                pos_next = index;
                            if (mark_reg > index)
                                mv_next = 1'b0;
                        end
                    cbb_pkg::F_MARK:
                    begin
                        mark_next = pos_reg;
                        mv_next = 1'b1;
                    end
                    cbb_pkg::F_RESET:
                        if (!mv_reg)
                            q_cmd.status = cbb_pkg::ST_MARK;
                        else
                            pos_next = mark_reg;
                    cbb_pkg::F_CLEAR:
                    begin
                        pos_next = '0;
                        lim_next = cap_now;
                        mv_next = 1'b0;
                    end
                    cbb_pkg::F_FLIP:
                    begin
                        lim_next = pos_reg;
                        pos_next = '0;
                        mv_next = 1'b0;
                    end
                    cbb_pkg::F_REWIND:
                    begin
                        pos_next = '0;
                        mv_next = 1'b0;
                    end
                    default:
                        if (ro_reg)
                            q_cmd.status = cbb_pkg::ST_READ_ONLY;
                        else
                        begin
                            q_cmd.op = cbb_pkg::OP_COMPACT;
                            q_cmd.addr = src[cbb_pkg::ADDR_W-1:0];
                            q_cmd.len = len[cbb_pkg::ADDR_W:0];
                            pos_next = count;
                            lim_next = cap_now;
                            mv_next = 1'b0;
                        end
                endcase
            end
            q_cmd.size_code = szc;
            q_cmd.msb_first = be_reg;
            q_cmd.wdata = write_value;
            q_cmd.pos = pos_next;
            q_cmd.lim = lim_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= '0;
            cap_reg <= cbb_pkg::CAP_RESET;
            be_reg <= 1'b1;
            ro_reg <= 1'b0;
            pos_reg <= '0;
            lim_reg <= cbb_pkg::eff_cap(2'd0, cbb_pkg::CAP_RESET);
            mark_reg <= '0;
            mv_reg <= 1'b0;
        end
        else
        begin
            esc_reg <= esc_next;
            cap_reg <= cap_next;
            be_reg <= be_next;
            ro_reg <= ro_next;
            pos_reg <= pos_next;
            lim_reg <= lim_next;
            mark_reg <= mark_next;
            mv_reg <= mv_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/cbb_queue.sv @@
`default_nettype none
module cbb_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire cbb_pkg::cmd_t  push_cmd,
    output logic                full,
    input  wire logic           pop,
    output cbb_pkg::cmd_t       head_cmd,
    output logic                head_valid
);

    cbb_pkg::cmd_t entry_reg [cbb_pkg::QDEPTH];
    logic [cbb_pkg::QPTR_W-1:0] wr_reg, rd_reg;
    logic [cbb_pkg::QPTR_W:0]   count_reg;

    assign full = (count_reg == (cbb_pkg::QPTR_W+1)'(cbb_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd = entry_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/cbb_back.sv @@
`default_nettype none
module cbb_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           rebuild,
    input  wire logic           q_valid,
    input  wire cbb_pkg::cmd_t  q_cmd,
    output logic                q_pop,
    output logic                clearing,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [63:0]         read_value,
    output logic [2:0]          status,
    output logic [12:0]         position_now,
    output logic [12:0]         limit_now
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_RADDR  = 7'b0000100,
        S_RDATA  = 7'b0001000,
        S_WRITE  = 7'b0010000,
        S_CREAD  = 7'b0100000,
        S_CWRITE = 7'b1000000
    } state_t;

    localparam int AW = cbb_pkg::ADDR_W;

    state_t state_reg, state_next;
    cbb_pkg::cmd_t cmd_reg, cmd_next;
    logic [AW:0]   k_reg, k_next;
    logic [63:0]   acc_reg, acc_next;
    logic          out_valid_reg;
    logic [63:0]   rv_reg;
    logic [2:0]    st_reg;
    logic [12:0]   pos_reg, lim_reg;

    logic [7:0]    mem [cbb_pkg::STORE_BYTES];
    logic [7:0]    rd_q;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [7:0]    mem_wd;

    logic          out_free, out_load;
    cbb_pkg::cmd_t fin_cmd;
    logic [63:0]   fin_rv;
    logic [2:0]    last_idx, byte_sel;

    assign out_free = !out_valid_reg || !out_stall;
    assign clearing = (state_reg == S_CLEAR);
    assign last_idx = 3'((4'd1 << cmd_reg.size_code) - 4'd1);
    assign byte_sel = cmd_reg.msb_first ? (last_idx - k_reg[2:0]) : k_reg[2:0];

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        k_next = k_reg;
        acc_next = acc_reg;
        q_pop = 1'b0;
        out_load = 1'b0;
        fin_cmd = cmd_reg;
        fin_rv = '0;
        mem_addr = cmd_reg.addr + k_reg[AW-1:0];
        mem_we = 1'b0;
        mem_wd = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_addr = k_reg[AW-1:0];
                mem_we = 1'b1;
                k_next = k_reg + 1'b1;
                if (k_reg[AW-1:0] == {AW{1'b1}})
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (q_valid && out_free && !rebuild)
                begin
                    q_pop = 1'b1;
                    cmd_next = q_cmd;
                    k_next = '0;
                    acc_next = '0;
                    case (q_cmd.op)
                        cbb_pkg::OP_READ:  state_next = S_RADDR;
                        cbb_pkg::OP_WRITE: state_next = S_WRITE;
                        cbb_pkg::OP_COMPACT:
                            if (q_cmd.len == '0)
                            begin
                                out_load = 1'b1;
                                fin_cmd = q_cmd;
                            end
                            else
                                state_next = S_CREAD;
                        default:
                        begin
                            out_load = 1'b1;
                            fin_cmd = q_cmd;
                        end
                    endcase
                end
            S_RADDR:
                state_next = S_RDATA;
            S_RDATA:
            begin
                if (cmd_reg.msb_first)
                    acc_next = {acc_reg[55:0], rd_q};
                else
                    acc_next = acc_reg | (64'(rd_q) << {k_reg[2:0], 3'b000});
                if (k_reg[2:0] == last_idx)
                begin
                    out_load = 1'b1;
                    fin_rv = acc_next;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_RADDR;
                end
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
                mem_wd = cmd_reg.wdata[{byte_sel, 3'b000} +: 8];
                k_next = k_reg + 1'b1;
                if (k_reg[2:0] == last_idx)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CREAD:
                state_next = S_CWRITE;
            S_CWRITE:
            begin
                // Destination trails the source, so a forward byte copy is safe.
                mem_addr = k_reg[AW-1:0];
                mem_we = 1'b1;
                mem_wd = rd_q;
                k_next = k_reg + 1'b1;
                if (k_next == cmd_reg.len)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_CREAD;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (rebuild)
        begin
            state_next = S_CLEAR;
            k_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        rd_q <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        acc_reg <= acc_next;
        if (out_load)
        begin
            rv_reg <= fin_rv;
            st_reg <= fin_cmd.status;
            pos_reg <= fin_cmd.pos;
            lim_reg <= fin_cmd.lim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            k_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_value = rv_reg;
    assign status = st_reg;
    assign position_now = pos_reg;
    assign limit_now = lim_reg;

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !q_pop)
        else $error("command taken during store clear");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result loaded over a pending transaction");

    a_write_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (k_reg[AW:3] == '0))
        else $error("scalar write ran past eight bytes");

endmodule
`default_nettype wire

@@ rtl/cursor_byte_buffer_engine_top.sv @@
// A cursor-only or failed item offers its result once the back end takes it from the queue; a get
// passes a read-address and a read-data state per byte, a put one write state per byte, a compact a
// read and a write state per moved byte. Cursor-only items go one per cycle while in_stall and
// out_stall stay low; after a store operation the back end returns to idle, where it takes the next
// command from the two-entry queue. Reset (asynchronous, active low) and any write of element size
// or capacity start a clearing pass over all 4096 store bytes, during which no input transaction is accepted.
`default_nettype none
module cursor_byte_buffer_engine_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  func,
    input  wire logic [12:0] index,
    input  wire logic [1:0]  scalar_size_code,
    input  wire logic [63:0] write_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      read_value,
    output logic [2:0]       status,
    output logic [12:0]      position_now,
    output logic [12:0]      limit_now
);

    logic          q_full, q_push, q_pop, q_valid, clearing, rebuild;
    cbb_pkg::cmd_t push_cmd, head_cmd;

    cbb_front u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .index(index), .scalar_size_code(scalar_size_code),
        .write_value(write_value),
        .q_full(q_full), .clearing(clearing),
        .q_push(q_push), .q_cmd(push_cmd), .rebuild(rebuild)
    );

    cbb_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_cmd(push_cmd), .full(q_full),
        .pop(q_pop), .head_cmd(head_cmd), .head_valid(q_valid)
    );

    cbb_back u_back (
        .clk(clk), .rst_n(rst_n), .rebuild(rebuild),
        .q_valid(q_valid), .q_cmd(head_cmd), .q_pop(q_pop), .clearing(clearing),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_value(read_value), .status(status),
        .position_now(position_now), .limit_now(limit_now)
    );

endmodule
`default_nettype wire

@@ verif/cursor_byte_buffer_engine_top_test.sv @@
`timescale 1ns / 100ps
`default_nettype none
module cursor_byte_buffer_engine_top_test;

    localparam logic [3:0] F_GET_REL = 4'd0;
    localparam logic [3:0] F_GET_ABS = 4'd1;
    localparam logic [3:0] F_PUT_REL = 4'd2;
    localparam logic [3:0] F_PUT_ABS = 4'd3;
    localparam logic [3:0] F_SGET_REL = 4'd4;
    localparam logic [3:0] F_SGET_ABS = 4'd5;
    localparam logic [3:0] F_SPUT_REL = 4'd6;
    localparam logic [3:0] F_SPUT_ABS = 4'd7;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  code;
        logic [12:0] pos;
        logic [12:0] lim;
    } answer_t;

    typedef struct {
        logic [3:0]  fn;
        logic [12:0] idx;
        logic [1:0]  ssc;
        logic [63:0] wv;
        logic        typed;
        answer_t     want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [3:0] func = '0;
    logic [12:0] index = '0;
    logic [1:0] scalar_size_code = '0;
    logic [63:0] write_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [63:0] read_value;
    logic [2:0] status;
    logic [12:0] position_now;
    logic [12:0] limit_now;

    cursor_byte_buffer_engine_top u_dut (.*);

    always #6 clk = ~clk;

    // Shadow copy of the buffer.
    logic [7:0]  mem [cbb_pkg::STORE_BYTES];
    logic [1:0]  m_esc;
    logic [12:0] m_cap;
    logic        m_be;
    logic        m_ro;
    logic [12:0] m_pos;
    logic [12:0] m_lim;
    logic [12:0] m_mark;
    logic        m_mark_ok;

    answer_t pending[$];
    int errors = 0;
    int out_wait = 0;
    bit rand_stall = 1'b0;

    function automatic int usable_cap();
        int most;
        most = cbb_pkg::STORE_BYTES >> m_esc;
        return (m_cap < most) ? m_cap : most;
    endfunction

    function automatic void rebuild_buffer();
        foreach (mem[i]) mem[i] = 8'h00;
        m_pos = '0;
        m_lim = 13'(usable_cap());
        m_mark = '0;
        m_mark_ok = 1'b0;
    endfunction

    function automatic answer_t buffer_step(logic [3:0] fn, logic [12:0] idx,
                                            logic [1:0] ssc, logic [63:0] wv);
        answer_t r;
        int sz, at, units, addr, cap, cnt, src;
        bit rel, put, scal;
        logic [7:0] tmp [cbb_pkg::STORE_BYTES];
        r = '0;
        r.code = cbb_pkg::ST_OK;
        cap = usable_cap();
        if (fn < 4'd8) begin
            scal = fn >= 4'd4;
            rel = fn[0] == 1'b0;
            put = fn[1];
            sz = 1 << (scal ? ssc : m_esc);
            at = rel ? m_pos : idx;
            units = scal ? sz : 1;
            if (put && m_ro) r.code = cbb_pkg::ST_READ_ONLY;
            else if (at + units > m_lim)
                r.code = rel ? (put ? cbb_pkg::ST_OVERFLOW : cbb_pkg::ST_UNDERFLOW)
                             : cbb_pkg::ST_INDEX;
            else begin
                addr = scal ? at : at * sz;
                for (int i = 0; i < sz; i++) begin
                    int a, sh;
                    a = addr + i;
                    sh = m_be ? (sz - 1 - i) * 8 : i * 8;
                    if (put) begin
                        if (a < cbb_pkg::STORE_BYTES) mem[a] = wv[sh +: 8];
                    end else if (a < cbb_pkg::STORE_BYTES) r.value[sh +: 8] = mem[a];
                end
                if (rel) m_pos = 13'(m_pos + units);
            end
        end else begin
            case (fn)
                cbb_pkg::F_SET_POS:
                    if (idx > m_lim) r.code = cbb_pkg::ST_ARGUMENT;
                    else begin
                        m_pos = idx;
                        if (m_mark_ok && m_mark > idx) m_mark_ok = 1'b0;
                    end
                cbb_pkg::F_SET_LIMIT:
                    if (idx > cap) r.code = cbb_pkg::ST_ARGUMENT;
                    else begin
                        m_lim = idx;
                        if (m_pos > idx) m_pos = idx;
                        if (m_mark_ok && m_mark > idx) m_mark_ok = 1'b0;
                    end
                cbb_pkg::F_MARK: begin m_mark = m_pos; m_mark_ok = 1'b1; end
                cbb_pkg::F_RESET:
                    if (!m_mark_ok) r.code = cbb_pkg::ST_MARK;
                    else m_pos = m_mark;
                cbb_pkg::F_CLEAR: begin m_pos = '0; m_lim = 13'(cap); m_mark_ok = 1'b0; end
                cbb_pkg::F_FLIP: begin m_lim = m_pos; m_pos = '0; m_mark_ok = 1'b0; end
                cbb_pkg::F_REWIND: begin m_pos = '0; m_mark_ok = 1'b0; end
                default:
                    if (m_ro) r.code = cbb_pkg::ST_READ_ONLY;
                    else begin
                        sz = 1 << m_esc;
                        cnt = (m_lim > m_pos) ? m_lim - m_pos : 0;
                        src = m_pos * sz;
                        if (src <= cbb_pkg::STORE_BYTES &&
                            cnt * sz <= cbb_pkg::STORE_BYTES - src) begin
                            tmp = mem;
                            for (int i = 0; i < cnt * sz; i++) mem[i] = tmp[src + i];
                        end
                        m_pos = 13'(cnt);
                        m_lim = 13'(cap);
                        m_mark_ok = 1'b0;
                    end
            endcase
        end
        r.pos = m_pos;
        r.lim = m_lim;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Only called while idle; geometry writes also start the clearing pass.
    task automatic write_reg(logic [1:0] which, logic [12:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (which)
            cbb_pkg::REG_ELEM_SIZE: begin m_esc = val[1:0]; rebuild_buffer(); end
            cbb_pkg::REG_CAPACITY: begin m_cap = val; rebuild_buffer(); end
            cbb_pkg::REG_BYTE_ORDER: m_be = val[0];
            default: m_ro = val[0];
        endcase
    endtask

    task automatic send_item(logic [3:0] fn, logic [12:0] idx, logic [1:0] ssc,
                             logic [63:0] wv, bit typed, answer_t want);
        answer_t p;
        int gap;
        gap = rand_stall ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        index <= idx;
        scalar_size_code <= ssc;
        write_value <= wv;
        do @(posedge clk); while (in_stall);
        p = buffer_step(fn, idx, ssc, wv);
        if (typed && p !== want) begin
            $display("%0t table row mismatch: expected %h actual model %h", $time, want, p);
            errors++;
        end
        pending = {pending, p};
        @(negedge clk);
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
    endtask

    function automatic logic [3:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22) return 4'($urandom_range(0, 3));
        if (r < 55) return 4'($urandom_range(4, 7));
        if (r < 70) return 4'($urandom_range(cbb_pkg::F_SET_POS, cbb_pkg::F_SET_LIMIT));
        if (r < 78) return cbb_pkg::F_MARK;
        if (r < 84) return cbb_pkg::F_RESET;
        if (r < 93) return 4'($urandom_range(cbb_pkg::F_CLEAR, cbb_pkg::F_REWIND));
        return cbb_pkg::F_COMPACT;
    endfunction

    function automatic logic [12:0] pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 13'($urandom_range(0, m_lim + 2));
        if (r < 8) return 13'($urandom_range(0, 40));
        return 13'($urandom);
    endfunction

    task automatic random_phase(int count);
        logic [3:0] fn;
        for (int i = 0; i < count; i++) begin
            fn = pick_func();
            send_item(fn, pick_index(), 2'($urandom), {$urandom, $urandom}, 1'b0, '0);
        end
        idle_input();
    endtask

    // Receiver side: after each result it holds off for a drawn number of cycles.
    always @(negedge clk) begin
        if (out_wait > 0) begin
            out_stall <= 1'b1;
            out_wait = out_wait - 1;
        end else
            out_stall <= 1'b0;
    end

    always @(posedge clk) begin
        answer_t got, exp;
        if (rst_n && out_valid && !out_stall) begin
            got = '{read_value, status, position_now, limit_now};
            if (pending.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                errors++;
            end else begin
                exp = pending.pop_front();
                if (got.value !== exp.value) begin
                    $display("%0t read_value expected %h actual %h", $time, exp.value, got.value);
                    errors++;
                end
                if (got.code !== exp.code) begin
                    $display("%0t status expected %0d actual %0d", $time, exp.code, got.code);
                    errors++;
                end
                if (got.pos !== exp.pos) begin
                    $display("%0t position_now expected %0d actual %0d", $time, exp.pos,
                             got.pos);
                    errors++;
                end
                if (got.lim !== exp.lim) begin
                    $display("%0t limit_now expected %0d actual %0d", $time, exp.lim, got.lim);
                    errors++;
                end
            end
            out_wait = rand_stall ? $urandom_range(0, 9) : 0;
        end
    end

    row_t plan [$];

    function automatic row_t mk(logic [3:0] fn, logic [12:0] idx, logic [1:0] ssc,
                                logic [63:0] wv, bit typed, answer_t want);
        row_t r;
        r.fn = fn;
        r.idx = idx;
        r.ssc = ssc;
        r.wv = wv;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    initial begin
        m_esc = 2'd0;
        m_cap = cbb_pkg::CAP_RESET;
        m_be = 1'b1;
        m_ro = 1'b0;
        rebuild_buffer();

        // Directed table, checked with the default geometry after reset.
        plan = {plan, mk(F_GET_REL, 0, 0, 0, 1,
                         '{64'd0, cbb_pkg::ST_OK, 13'd1, 13'd4096})};
        plan = {plan, mk(F_GET_ABS, 4095, 0, 0, 1,
                         '{64'd0, cbb_pkg::ST_OK, 13'd1, 13'd4096})};
        plan = {plan, mk(F_GET_ABS, 4096, 0, 0, 1,
                         '{64'd0, cbb_pkg::ST_INDEX, 13'd1, 13'd4096})};
        plan = {plan, mk(cbb_pkg::F_RESET, 0, 0, 0, 1,
                         '{64'd0, cbb_pkg::ST_MARK, 13'd1, 13'd4096})};
        plan = {plan, mk(cbb_pkg::F_SET_POS, 8191, 0, 0, 1,
                         '{64'd0, cbb_pkg::ST_ARGUMENT, 13'd1, 13'd4096})};
        plan = {plan, mk(cbb_pkg::F_SET_LIMIT, 4097, 0, 0, 1,
                         '{64'd0, cbb_pkg::ST_ARGUMENT, 13'd1, 13'd4096})};
        plan = {plan, mk(F_PUT_ABS, 4095, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, '0)};
        plan = {plan, mk(F_SPUT_ABS, 8, 3, 64'h0123_4567_89AB_CDEF, 0, '0)};
        plan = {plan, mk(F_SGET_ABS, 8, 3, 0, 0, '0)};
        plan = {plan, mk(F_SGET_ABS, 8, 2, 0, 0, '0)};
        plan = {plan, mk(F_SGET_ABS, 4093, 3, 0, 0, '0)};
        plan = {plan, mk(F_SPUT_REL, 0, 1, 64'hAAAA, 0, '0)};
        plan = {plan, mk(F_SGET_REL, 0, 0, 0, 0, '0)};
        plan = {plan, mk(F_PUT_REL, 0, 0, 64'h5A, 0, '0)};
        plan = {plan, mk(cbb_pkg::F_MARK, 0, 0, 0, 0, '0)};
        plan = {plan, mk(cbb_pkg::F_SET_POS, 10, 0, 0, 0, '0)};
        plan = {plan, mk(cbb_pkg::F_RESET, 0, 0, 0, 0, '0)};
        plan = {plan, mk(cbb_pkg::F_SET_LIMIT, 2, 0, 0, 0, '0)};
        plan = {plan, mk(F_GET_REL, 0, 0, 0, 0, '0)};
        plan = {plan, mk(F_PUT_REL, 0, 0, 1, 0, '0)};
        plan = {plan, mk(cbb_pkg::F_FLIP, 0, 0, 0, 0, '0)};
        plan = {plan, mk(cbb_pkg::F_COMPACT, 0, 0, 0, 0, '0)};
        plan = {plan, mk(cbb_pkg::F_REWIND, 0, 0, 0, 0, '0)};
        plan = {plan, mk(cbb_pkg::F_CLEAR, 0, 0, 0, 0, '0)};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_item(plan[i].fn, plan[i].idx, plan[i].ssc, plan[i].wv,
                      plan[i].typed, plan[i].want);
        idle_input();
        wait_drained();

        rand_stall = 1'b1;
        random_phase(300);
        wait_drained();

        write_reg(cbb_pkg::REG_READ_ONLY, 13'd1);
        write_reg(cbb_pkg::REG_BYTE_ORDER, 13'd0);
        random_phase(100);
        wait_drained();

        write_reg(cbb_pkg::REG_READ_ONLY, 13'd0);
        write_reg(cbb_pkg::REG_ELEM_SIZE, 13'd3);
        write_reg(cbb_pkg::REG_CAPACITY, 13'd24);
        random_phase(300);
        wait_drained();

        write_reg(cbb_pkg::REG_ELEM_SIZE, 13'd1);
        write_reg(cbb_pkg::REG_CAPACITY, 13'd0);
        random_phase(60);
        wait_drained();

        write_reg(cbb_pkg::REG_BYTE_ORDER, 13'd1);
        write_reg(cbb_pkg::REG_CAPACITY, 13'd8191);
        rand_stall = 1'b0;
        random_phase(150);
        rand_stall = 1'b1;
        wait_drained();

        write_reg(cbb_pkg::REG_ELEM_SIZE, 13'd2);
        write_reg(cbb_pkg::REG_CAPACITY, 13'd40);
        random_phase(400);
        wait_drained();

        write_reg(cbb_pkg::REG_ELEM_SIZE, 13'd0);
        write_reg(cbb_pkg::REG_CAPACITY, 13'd64);
        write_reg(cbb_pkg::REG_BYTE_ORDER, 13'd0);
        random_phase(540);
        wait_drained();

        if (errors == 0)
            $display("cursor_byte_buffer_engine_top_test: done, clean");
        else
            $display("cursor_byte_buffer_engine_top_test: done, errors");
        $finish;
    end

    initial begin
        #(12 * 40_000_000);
        $display("cursor_byte_buffer_engine_top_test: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/cbb_pkg.sv
rtl/cbb_front.sv
rtl/cbb_queue.sv
rtl/cbb_back.sv
rtl/cursor_byte_buffer_engine_top.sv
verif/cursor_byte_buffer_engine_top_test.sv
